>>> rtl/core/cfs_pkg.sv
// Shared types, codes and helpers for the Coulomb field summation unit.
// No dependencies.
`default_nettype none
package cfs_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [2:0]  CFG_ADDR_SCALE = 3'd0;
  localparam logic [31:0] SCALE_RESET    = 32'h0001_0000;
  localparam logic [6:0]  DIV_A_STEPS    = 7'd64;
  localparam logic [6:0]  DIV_U_STEPS    = 7'd48;
  localparam logic [63:0] SQRT_BIT_INIT  = 64'h4000_0000_0000_0000;
  localparam logic [46:0] A_CLAMP        = {47{1'b1}};

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } sat_t;

  // clamp a signed value to the 32-bit signed range
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.val = 32'h7FFF_FFFF;
      r.ov  = 1'b1;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r.val = 32'h8000_0000;
      r.ov  = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/cfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module cfs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/coulomb_field_summation_unit.sv
// Coulomb field summation unit: charge store, per-charge field walk, output scaling.
// Depends on cfs_pkg and cfs_ram.
`default_nettype none
// Usage:
//  in_*  : stream of requests. in_tuser holds the action (clear, append, query);
//          in_tdata holds pos_x, pos_y, pos_z, charge_value (Q16.16).
//  out_* : one result per query: field_x/y/z (Q16.16, saturated) plus the
//          overflow and coincident flags.
//  cfg_* : APB-style port, force_scale at byte address 0.
//  Clear and append finish in the cycle they are accepted (append to a full
//  store is dropped). A query is one request at a time: it walks the stored
//  charges from a single RAM (one entry read per charge). Each charge passes
//  through read and difference, squares, the 64-step serial divider for
//  |q|/|d|^2 with the square root alongside, framed by its setup and the clamp,
//  three unit-vector passes around a 48-step division, and an advance step; a
//  coincident charge goes straight from the difference to the advance. Scaling
//  and output follow the last charge; the next request can be taken once the
//  result is in the output register. in_tready is high only while no query
//  is in flight. A result waits in the output register while the receiver
//  stalls; new requests are taken meanwhile. Reset empties the store (count
//  to zero) and sets force_scale to 1.0.
module coulomb_field_summation_unit #(
  parameter int MAX_CHARGES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // pos_x, pos_y, pos_z, charge_value
  input  wire logic [1:0]   in_tuser,  // action
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [103:0] out_tdata, // field_x, field_y, field_z, overflow, coincident, pad
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic      [31:0]  cfg_prdata,
  output logic              cfg_pready
);
  import cfs_pkg::*;

  localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int CW = $clog2(MAX_CHARGES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIFF, S_SQ, S_DSTART, S_DIVA, S_ASET, S_USET,
    S_UDIV, S_MUL, S_TERM, S_NEXT, S_SCALE, S_SAT, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [31:0] scale_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_SCALE) ? scale_r : 32'd0;

  // store
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  logic          in_acc, ram_we;
  logic [127:0]  rdata;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ram_we    = in_acc && (action_t'(in_tuser) == ACT_APPEND) &&
                     (count_r < CW'(MAX_CHARGES));

  cfs_ram #(.WIDTH(128), .DEPTH(MAX_CHARGES)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(in_tdata),
    .raddr(idx_r),
    .rdata(rdata)
  );

  // query working registers
  logic [31:0]        p_r   [3];
  logic [31:0]        dm_r  [3];
  logic               dn_r  [3];
  logic signed [31:0] acc_r [3];
  logic [31:0]        fld_r [3];
  logic [1:0]         ax_r;
  logic               qneg_r;
  logic [31:0]        qm_r;
  logic [63:0]        s_r;
  logic [46:0]        a_r;
  logic [31:0]        m_r;
  logic [63:0]        prod_r;
  logic signed [63:0] sc_r;
  logic               ov_r, coin_r;

  // serial divider and square root
  logic [63:0] dv_num_r, dv_den_r, dv_rem_r, dv_quo_r;
  logic [6:0]  cnt_r;
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r;

  logic [64:0] rem_sh, rem_new;
  logic        dv_ge;
  logic [63:0] sq_sum;

  always_comb begin
    rem_sh  = {dv_rem_r, dv_num_r[63]};
    dv_ge   = rem_sh >= {1'b0, dv_den_r};
    rem_new = dv_ge ? rem_sh - {1'b0, dv_den_r} : rem_sh;
    sq_sum  = sq_res_r + sq_bit_r;
  end

  // per-charge difference
  logic signed [32:0] d33 [3];
  logic               coin_now;
  sat_t               dsat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d33[c]  = $signed({p_r[c][31], p_r[c]}) -
                $signed({rdata[32*c+31], rdata[32*c +: 32]});
      dsat[c] = sat32(64'(d33[c]));
    end
    coin_now = (d33[0] == 33'sd0) && (d33[1] == 33'sd0) && (d33[2] == 33'sd0);
  end

  // term accumulate and output scaling
  logic [47:0]        term;
  logic signed [63:0] sum_w;
  sat_t               acc_sat;
  logic [62:0]        sc_mag;
  logic [46:0]        sc_shr;
  logic signed [63:0] sc_val;
  sat_t               fld_sat;

  always_comb begin
    term    = prod_r[63:16];
    sum_w   = 64'(acc_r[ax_r]) +
              ((qneg_r ^ dn_r[ax_r]) ? -$signed({16'd0, term}) : $signed({16'd0, term}));
    acc_sat = sat32(sum_w);
    sc_mag  = sc_r[63] ? 63'(-sc_r) : sc_r[62:0];
    sc_shr  = sc_mag[62:16];
    sc_val  = sc_r[63] ? -$signed({17'd0, sc_shr}) : $signed({17'd0, sc_shr});
    fld_sat = sat32(sc_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scale_r    <= SCALE_RESET;
      count_r    <= '0;
      idx_r      <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == CFG_ADDR_SCALE) begin
        scale_r <= cfg_pwdata;
      end
      // S_OUT drives out_tvalid itself
      if (out_tvalid && out_tready && state_r != S_OUT) begin
        out_tvalid <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (action_t'(in_tuser))
              ACT_CLEAR:  count_r <= '0;
              ACT_APPEND: if (ram_we) count_r <= count_r + CW'(1);
              ACT_QUERY: begin
                p_r[0] <= in_tdata[31:0];
                p_r[1] <= in_tdata[63:32];
                p_r[2] <= in_tdata[95:64];
                for (int c = 0; c < 3; c++) acc_r[c] <= '0;
                ov_r   <= 1'b0;
                coin_r <= 1'b0;
                idx_r  <= '0;
                ax_r   <= '0;
                state_r <= (count_r == '0) ? S_SCALE : S_LOAD;
              end
              default: ;
            endcase
          end
        end
        S_LOAD: state_r <= S_DIFF;   // RAM read in flight
        S_DIFF: begin
          if (coin_now) begin
            coin_r  <= 1'b1;
            state_r <= S_NEXT;
          end else begin
            for (int c = 0; c < 3; c++) begin
              dm_r[c] <= dsat[c].val[31] ? 32'd0 - dsat[c].val : dsat[c].val;
              dn_r[c] <= dsat[c].val[31];
            end
            if (dsat[0].ov || dsat[1].ov || dsat[2].ov) ov_r <= 1'b1;
            qneg_r  <= rdata[127];
            qm_r    <= rdata[127] ? 32'd0 - rdata[127:96] : rdata[127:96];
            s_r     <= '0;
            ax_r    <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          s_r <= s_r + 64'(dm_r[ax_r]) * 64'(dm_r[ax_r]);
          if (ax_r == 2'd2) state_r <= S_DSTART;
          else ax_r <= ax_r + 2'd1;
        end
        S_DSTART: begin
          dv_num_r <= {qm_r, 32'd0};
          dv_den_r <= s_r;
          dv_rem_r <= '0;
          dv_quo_r <= '0;
          cnt_r    <= DIV_A_STEPS;
          sq_v_r   <= s_r;
          sq_res_r <= '0;
          sq_bit_r <= SQRT_BIT_INIT;
          state_r  <= S_DIVA;
        end
        S_DIVA: begin
          dv_rem_r <= rem_new[63:0];
          dv_quo_r <= {dv_quo_r[62:0], dv_ge};
          dv_num_r <= {dv_num_r[62:0], 1'b0};
          cnt_r    <= cnt_r - 7'd1;
          if (sq_bit_r != '0) begin
            if (sq_v_r >= sq_sum) begin
              sq_v_r   <= sq_v_r - sq_sum;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
          if (cnt_r == 7'd1) state_r <= S_ASET;
        end
        S_ASET: begin
          if (dv_quo_r[63:47] != '0) begin
            a_r  <= A_CLAMP;
            ov_r <= 1'b1;
          end else begin
            a_r <= dv_quo_r[46:0];
          end
          m_r     <= sq_res_r[31:0];
          ax_r    <= '0;
          state_r <= S_USET;
        end
        S_USET: begin
          dv_num_r <= {dm_r[ax_r], 32'd0};
          dv_den_r <= {32'd0, m_r};
          dv_rem_r <= '0;
          dv_quo_r <= '0;
          cnt_r    <= DIV_U_STEPS;
          state_r  <= S_UDIV;
        end
        S_UDIV: begin
          dv_rem_r <= rem_new[63:0];
          dv_quo_r <= {dv_quo_r[62:0], dv_ge};
          dv_num_r <= {dv_num_r[62:0], 1'b0};
          cnt_r    <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= 64'(a_r) * 64'(dv_quo_r[16:0]);
          state_r <= S_TERM;
        end
        S_TERM: begin
          acc_r[ax_r] <= acc_sat.val;
          if (acc_sat.ov) ov_r <= 1'b1;
          if (ax_r == 2'd2) begin
            state_r <= S_NEXT;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_USET;
          end
        end
        S_NEXT: begin
          if (CW'(idx_r) + CW'(1) == count_r) begin
            ax_r    <= '0;
            state_r <= S_SCALE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_LOAD;
          end
        end
        S_SCALE: begin
          sc_r    <= 64'(acc_r[ax_r]) * 64'($signed(scale_r));
          state_r <= S_SAT;
        end
        S_SAT: begin
          fld_r[ax_r] <= fld_sat.val;
          if (fld_sat.ov) ov_r <= 1'b1;
          if (ax_r == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_SCALE;
          end
        end
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tdata  <= {6'd0, coin_r, ov_r, fld_r[2], fld_r[1], fld_r[0]};
            out_tvalid <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_CHARGES))
    else $error("charge count above store depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (CW'(idx_r) < count_r))
    else $error("query reads past the stored charges");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("request taken while a query runs");

  a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_tvalid || out_tready)) |=> out_tvalid)
    else $error("finished query did not present a result");
`endif

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for coulomb_field_summation_unit: streamed clear/append/query
// requests, a bit-exact field predictor, APB writes of force_scale. Depends on cfs_pkg and the unit.
`timescale 1ns / 100ps
module tb;
  import cfs_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int WATCHDOG    = 100000; // worst-case query plus long stalls
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    action_t     act;
    logic [31:0] x, y, z, q;
  } request_t;

  typedef struct {
    logic [31:0] fx, fy, fz;
    logic        ov, co;
  } field_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;    // pos_x, pos_y, pos_z, charge_value
  logic [1:0]   in_tuser = ACT_CLEAR; // action
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;        // field_x, field_y, field_z, overflow, coincident, pad
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  coulomb_field_summation_unit uut (.*);

  always #10 clk = ~clk;

  // requests waiting for the driver, fields expected from the block
  request_t pending_reqs[$];
  field_t   expected_fields[$];

  // predictor state
  logic [31:0] mdl_x[STORE_DEPTH], mdl_y[STORE_DEPTH], mdl_z[STORE_DEPTH];
  logic [31:0] mdl_q[STORE_DEPTH];
  int          mdl_count = 0;
  logic [31:0] mdl_scale = SCALE_RESET;

  int  mismatches = 0;
  bit  calm = 0;      // no idling on either side
  bit  hold_req = 0;  // ask the receiver for one long hold-off
  int  idle_cycles = 0;

  function automatic longint sat_to32(longint v, inout bit ov);
    if (v > 64'sd2147483647) begin ov = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin ov = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0, b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // field at point p summed over the stored charges, then scaled
  function automatic field_t field_at(request_t rq);
    longint p[3], acc[3], d[3], q, st, prod, r;
    longint unsigned s, m, a, qm, u, t, pm;
    bit ov = 0, co = 0, neg;
    field_t f;
    p[0] = longint'($signed(rq.x));
    p[1] = longint'($signed(rq.y));
    p[2] = longint'($signed(rq.z));
    acc = '{0, 0, 0};
    for (int i = 0; i < mdl_count; i++) begin
      d[0] = p[0] - longint'($signed(mdl_x[i]));
      d[1] = p[1] - longint'($signed(mdl_y[i]));
      d[2] = p[2] - longint'($signed(mdl_z[i]));
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
        co = 1;
        continue;
      end
      s = 0;
      for (int c = 0; c < 3; c++) begin
        d[c] = sat_to32(d[c], ov);
        s += longint'(d[c] * d[c]);
      end
      m  = root_floor(s);
      q  = longint'($signed(mdl_q[i]));
      qm = mag(q);
      a  = (qm << 32) / s;
      if (a > {17'd0, A_CLAMP}) begin
        a  = {17'd0, A_CLAMP};
        ov = 1;
      end
      for (int c = 0; c < 3; c++) begin
        u   = (mag(d[c]) << 16) / m;
        t   = (a * u) >> 16;
        neg = (q < 0) != (d[c] < 0);
        st  = neg ? -longint'(t) : longint'(t);
        acc[c] = sat_to32(acc[c] + st, ov);
      end
    end
    for (int c = 0; c < 3; c++) begin
      prod = acc[c] * longint'($signed(mdl_scale));
      pm   = mag(prod) >> 16;
      r    = prod < 0 ? -longint'(pm) : longint'(pm);
      r    = sat_to32(r, ov);
      if (c == 0) f.fx = r[31:0];
      else if (c == 1) f.fy = r[31:0];
      else f.fz = r[31:0];
    end
    f.ov = ov;
    f.co = co;
    return f;
  endfunction

  // apply one accepted request to the predictor
  task automatic take_request(request_t rq);
    case (rq.act)
      ACT_CLEAR: mdl_count = 0;
      ACT_APPEND:
        if (mdl_count < STORE_DEPTH) begin
          mdl_x[mdl_count] = rq.x;
          mdl_y[mdl_count] = rq.y;
          mdl_z[mdl_count] = rq.z;
          mdl_q[mdl_count] = rq.q;
          mdl_count++;
        end
      ACT_QUERY: expected_fields = {expected_fields, field_at(rq)};
      default: ;
    endcase
  endtask

  // ---------------- driver: feeds pending_reqs onto the input stream
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        take_request(pending_reqs[0]);
        void'(pending_reqs.pop_front());
      end
      // a request on offer stays put until taken
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(0, 14);
            in_tvalid <= 1'b0;
          end else begin
            in_tvalid <= 1'b1;
            in_tuser  <= pending_reqs[0].act;
            in_tdata  <= {pending_reqs[0].q, pending_reqs[0].z,
                          pending_reqs[0].y, pending_reqs[0].x};
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor: receiver stalls and result checking
  int out_stall = 0, hold_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_fields.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          field_t e;
          e = expected_fields.pop_front();
          if (out_tdata[31:0] !== e.fx || out_tdata[63:32] !== e.fy ||
              out_tdata[95:64] !== e.fz || out_tdata[96] !== e.ov ||
              out_tdata[97] !== e.co) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field mismatch: exp x=%h y=%h z=%h ov=%b co=%b got x=%h y=%h z=%h ov=%b co=%b",
                       e.fx, e.fy, e.fz, e.ov, e.co, out_tdata[31:0], out_tdata[63:32],
                       out_tdata[95:64], out_tdata[96], out_tdata[97]);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog on lack of progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- stimulus
  function automatic logic [31:0] coord();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic request_t make_req(action_t act, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [31:0] q);
    request_t r;
    r.act = act; r.x = x; r.y = y; r.z = z; r.q = q;
    return r;
  endfunction

  // append one request to the driver's queue
  task automatic queue_req(request_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || expected_fields.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= CFG_ADDR_SCALE; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    mdl_scale = v;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // clear, n_charges appends, then queries, some at a stored charge position
  task automatic push_sequence(int n_charges);
    request_t r;
    logic [31:0] px[$], py[$], pz[$];
    int k;
    queue_req(make_req(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom));
    for (int i = 0; i < n_charges; i++) begin
      r = make_req(ACT_APPEND, coord(), coord(), coord(),
                   $urandom_range(0, 3) == 0 ? coord() : $urandom_range(0, 32'h0004_0000)
                                                         - 32'h0002_0000);
      px = {px, r.x}; py = {py, r.y}; pz = {pz, r.z};
      queue_req(r);
    end
    repeat ($urandom_range(1, 4)) begin
      r = make_req(ACT_QUERY, coord(), coord(), coord(), $urandom);
      if (n_charges > 0 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, n_charges - 1);
        r.x = px[k]; r.y = py[k]; r.z = pz[k];
      end
      queue_req(r);
    end
  endtask

  task automatic push_random(int n_items);
    int goal;
    goal = pending_reqs.size() + n_items;
    while (pending_reqs.size() < goal) begin
      if ($urandom_range(0, 4) != 0) begin
        push_sequence($urandom_range(0, 49) == 0 ? 66 : $urandom_range(1, 6));
      end else begin
        // noise: any action code, any content
        queue_req(make_req(action_t'($urandom_range(0, 3)), $urandom,
                           $urandom, $urandom, $urandom));
      end
    end
  endtask

  logic [31:0] scales[5];

  initial begin
    scales = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h0, 32'h0001_0000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset gain
    queue_req(make_req(ACT_QUERY, 0, 0, 0, 0));              // empty store
    queue_req(make_req(ACT_APPEND, 0, 0, 0, 32'h0001_0000));
    queue_req(make_req(ACT_QUERY, 32'h0001_0000, 0, 0, 0));
    queue_req(make_req(ACT_QUERY, 0, 32'hFFFF_0000, 32'h0002_0000, 0));
    queue_req(make_req(ACT_QUERY, 0, 0, 0, 0));              // coincident
    queue_req(make_req(ACT_APPEND, 32'h0003_0000, 0, 0, 0)); // zero charge
    queue_req(make_req(ACT_QUERY, 32'h0002_0000, 0, 0, 0));
    queue_req(make_req(ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000));
    queue_req(make_req(ACT_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       0));                                  // difference saturates
    queue_req(make_req(ACT_APPEND, 32'h0000_0001, 0, 0, 32'h7FFF_FFFF));
    queue_req(make_req(ACT_QUERY, 0, 0, 0, 0));              // huge a, clamp
    queue_req(make_req(ACT_NONE, $urandom, $urandom, $urandom, $urandom));
    queue_req(make_req(ACT_CLEAR, 0, 0, 0, 0));
    queue_req(make_req(ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF));
    wait_idle();

    // full store: the two appends past the limit are dropped
    push_sequence(66);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_scale(ph == 3 ? $urandom : scales[ph]);
      if (ph == 1) hold_req = 1;
      if (ph == 4) calm = 1;
      push_random(350);
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_fields.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
